// ===== rtl/core/prc_pkg.sv =====
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, constants, register map, microcode table and control types
// of the PID rotor pulse controller.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int IN_W    = 16;   // measured time / target time
    localparam int ERR_W   = 17;   // exact error
    localparam int DIFF_W  = 18;   // error change
    localparam int GAIN_W  = 24;   // unsigned Q8.16 gains
    localparam int DIV_W   = 8;    // derivative time step
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + DIFF_W;
    localparam int MAG_W   = GAIN_W + ERR_W;   // magnitude of any product
    localparam int ACC_W   = 40;
    localparam int SUM_W   = 44;
    localparam int OUT_W   = 12;
    localparam int Q_FRAC  = 16;
    localparam int CLAMP_W = 27;   // magnitude bits of the clamped sum
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam int CNT_W   = $clog2(MAG_W);

    localparam logic [CNT_W-1:0] DIV_LAST_CNT = CNT_W'(MAG_W - 1);

    // register map, index = paddr / 4
    localparam logic [REG_IDX_W-1:0] REG_TARGET   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I   = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_STEP_DIV = REG_IDX_W'(4);

    localparam logic signed [IN_W-1:0] TARGET_RST  = IN_W'(1000);
    localparam logic [GAIN_W-1:0]      GAIN_P_RST  = GAIN_W'(98304);
    localparam logic [GAIN_W-1:0]      GAIN_I_RST  = GAIN_W'(2621);
    localparam logic [GAIN_W-1:0]      GAIN_D_RST  = GAIN_W'(32768);
    localparam logic [DIV_W-1:0]       STEP_DIV_RST = DIV_W'(5);

    localparam logic signed [ERR_W-1:0] BAND_HI = ERR_W'(400);
    localparam logic signed [ERR_W-1:0] BAND_LO = -BAND_HI;

    localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) << (ACC_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

    localparam int DRIVE_LIMIT = 2000;
    localparam logic signed [SUM_W-1:0] DRIVE_MAX_Q = SUM_W'(DRIVE_LIMIT * (1 << Q_FRAC));
    localparam logic signed [SUM_W-1:0] DRIVE_MIN_Q = -DRIVE_MAX_Q;
    localparam logic signed [OUT_W-1:0] DRIVE_HI    = OUT_W'(DRIVE_LIMIT);
    localparam logic signed [OUT_W-1:0] DRIVE_LO    = -DRIVE_HI;
    localparam logic [OUT_W-1:0] PULSE_CENTER = OUT_W'(1500);
    localparam logic [OUT_W-1:0] PULSE_MIN    = OUT_W'(500);
    localparam logic [OUT_W-1:0] PULSE_MAX    = OUT_W'(2500);

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_ADD_D,
        ST_EMIT
    } step_t;

    typedef enum logic [2:0] {
        OP_LOAD_ERR,
        OP_MUL_P,
        OP_MUL_I,
        OP_MUL_D,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_ADD_D,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        COND_NEXT,      // fire and advance
        COND_WAIT_IN,   // fire and advance on an input beat
        COND_LOOP_DIV,  // fire every cycle, advance on the last divider step
        COND_WAIT_OUT   // fire and advance once the output register is free
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            ST_WAIT:     w = '{op: OP_LOAD_ERR, cond: COND_WAIT_IN,  target: ST_MUL_P};
            ST_MUL_P:    w = '{op: OP_MUL_P,    cond: COND_NEXT,     target: ST_MUL_I};
            ST_MUL_I:    w = '{op: OP_MUL_I,    cond: COND_NEXT,     target: ST_MUL_D};
            ST_MUL_D:    w = '{op: OP_MUL_D,    cond: COND_NEXT,     target: ST_DIV_LOAD};
            ST_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NEXT,     target: ST_DIV_RUN};
            ST_DIV_RUN:  w = '{op: OP_DIV_STEP, cond: COND_LOOP_DIV, target: ST_ADD_D};
            ST_ADD_D:    w = '{op: OP_ADD_D,    cond: COND_NEXT,     target: ST_EMIT};
            ST_EMIT:     w = '{op: OP_EMIT,     cond: COND_WAIT_OUT, target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/prc_in_if.sv =====
// ----------------------------------------------------------------------------
// prc_in_if
// Sample channel: one measured time per beat.
// ----------------------------------------------------------------------------
interface prc_in_if;
    import prc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] measured_time;

    modport source (output valid, output measured_time, input ready);
    modport sink   (input valid, input measured_time, output ready);
endinterface

// ===== rtl/core/prc_out_if.sv =====
// ----------------------------------------------------------------------------
// prc_out_if
// Result channel: clamped drive and rotor pulse width per beat.
// ----------------------------------------------------------------------------
interface prc_out_if;
    import prc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] drive;
    logic [OUT_W-1:0]        rotor_pulse;

    modport source (output valid, output drive, output rotor_pulse, input ready);
    modport sink   (input valid, input drive, input rotor_pulse, output ready);
endinterface

// ===== rtl/core/prc_div.sv =====
// ----------------------------------------------------------------------------
// prc_div
// Bit-serial restoring divider: unsigned magnitude by an 8-bit divisor,
// one quotient bit per step, quotient truncated.
// ----------------------------------------------------------------------------
module prc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  prc_pkg::div_ctrl_t        ctrl,
    input  logic [prc_pkg::MAG_W-1:0] dividend,
    input  logic [prc_pkg::DIV_W-1:0] divisor,
    output logic [prc_pkg::MAG_W-1:0] quotient,
    output logic                      last
);
    import prc_pkg::*;

    logic [MAG_W-1:0] dq_reg;    // dividend bits out the top, quotient bits in
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] trial;
    logic             qbit;

    always_comb
    begin
        shifted = {rem_reg, dq_reg[MAG_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dsr_reg};
        qbit    = ~trial[DIV_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= DIV_LAST_CNT;
        end
        else if (ctrl.step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (ctrl.step)
        begin
            dq_reg  <= {dq_reg[MAG_W-2:0], qbit};
            rem_reg <= qbit ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        end
    end

    assign quotient = dq_reg;
    assign last     = (cnt_reg == '0);

endmodule

// ===== rtl/core/pid_rotor_pulse_controller.sv =====
// ----------------------------------------------------------------------------
// pid_rotor_pulse_controller
// PID step per measured time sample with integral band reset, driven by a
// microcoded sequencer over one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Sequence: a sample beat runs the P, I and D multiplies, the divider load, the
//   41 steps of the bit-serial divider for the derivative term, the D add and
//   the emit step, which loads the result register once it is free; the result
//   shows from the next cycle on. A new sample is taken only after the emit.
// Reset: rst_n clears the step counter, the integral, the previous error,
//   the output valid and restores the register defaults.
module pid_rotor_pulse_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [prc_pkg::ADDR_W-1:0] paddr,
    input  logic [prc_pkg::DATA_W-1:0] pwdata,
    output logic [prc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    prc_in_if.sink                     sample,
    prc_out_if.source                  result
);
    import prc_pkg::*;

    // configuration
    logic signed [IN_W-1:0] target_reg;
    logic [GAIN_W-1:0]      gain_p_reg;
    logic [GAIN_W-1:0]      gain_i_reg;
    logic [GAIN_W-1:0]      gain_d_reg;
    logic [DIV_W-1:0]       step_div_reg;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;

    // sequencer
    step_t     step_reg;
    step_t     step_next;
    ucode_t    uc;
    logic      fire;
    logic      advance;
    logic      out_free;
    div_ctrl_t div_ctrl;
    logic      div_last;

    // datapath
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     d_neg_reg;

    logic signed [ERR_W-1:0]   err_new;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  product;
    logic                      in_band;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_sat;
    logic signed [PROD_W-1:0]  prod_abs;
    logic [MAG_W-1:0]          quotient;
    logic [DIV_W-1:0]          div_eff;
    logic signed [SUM_W-1:0]   q_ext;
    logic signed [SUM_W-1:0]   d_val;
    logic signed [SUM_W-1:0]   clamped;
    logic signed [SUM_W-1:0]   clamped_abs;
    logic [CLAMP_W-1:0]        clamp_mag;
    logic [OUT_W-1:0]          drive_mag;
    logic [OUT_W-1:0]          half_mag;
    logic signed [OUT_W-1:0]   drive_new;
    logic [OUT_W-1:0]          pulse_new;

    // output register
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] drive_reg;
    logic [OUT_W-1:0]        pulse_reg;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RST;
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= GAIN_I_RST;
            gain_d_reg   <= GAIN_D_RST;
            step_div_reg <= STEP_DIV_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TARGET:   target_reg   <= pwdata[IN_W-1:0];
                REG_GAIN_P:   gain_p_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   gain_i_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   gain_d_reg   <= pwdata[GAIN_W-1:0];
                REG_STEP_DIV: step_div_reg <= pwdata[DIV_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TARGET:   prdata = DATA_W'($unsigned(target_reg));
            REG_GAIN_P:   prdata = DATA_W'(gain_p_reg);
            REG_GAIN_I:   prdata = DATA_W'(gain_i_reg);
            REG_GAIN_D:   prdata = DATA_W'(gain_d_reg);
            REG_STEP_DIV: prdata = DATA_W'(step_div_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign out_free     = ~out_valid_reg | result.ready;
    assign sample.ready = (uc.cond == COND_WAIT_IN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        uc = ucode_rom(step_reg);
        unique case (uc.cond)
            COND_NEXT:
            begin
                fire    = 1'b1;
                advance = 1'b1;
            end
            COND_WAIT_IN:
            begin
                fire    = sample.valid;
                advance = sample.valid;
            end
            COND_LOOP_DIV:
            begin
                fire    = 1'b1;
                advance = div_last;
            end
            COND_WAIT_OUT:
            begin
                fire    = out_free;
                advance = out_free;
            end
        endcase
        step_next     = advance ? uc.target : step_reg;
        div_ctrl.load = fire && (uc.op == OP_DIV_LOAD);
        div_ctrl.step = fire && (uc.op == OP_DIV_STEP);
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        err_new = ERR_W'(sample.measured_time) - ERR_W'(target_reg);
        diff    = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        in_band = (err_reg > BAND_LO) && (err_reg < BAND_HI);

        // one shared multiplier, operands picked by the control word
        unique case (uc.op)
            OP_MUL_I:
            begin
                mul_a = {1'b0, gain_i_reg};
                mul_b = DIFF_W'(err_reg);
            end
            OP_MUL_D:
            begin
                mul_a = {1'b0, gain_d_reg};
                mul_b = diff;
            end
            default:
            begin
                mul_a = {1'b0, gain_p_reg};
                mul_b = DIFF_W'(err_reg);
            end
        endcase
        product = PROD_W'(mul_a) * PROD_W'(mul_b);

        acc_sum = SUM_W'(acc_reg) + SUM_W'(prod_reg);
        if (acc_sum > ACC_MAX)
        begin
            acc_sat = ACC_MAX[ACC_W-1:0];
        end
        else if (acc_sum < ACC_MIN)
        begin
            acc_sat = ACC_MIN[ACC_W-1:0];
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end

        prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
        div_eff  = (step_div_reg == '0) ? DIV_W'(1) : step_div_reg;
        q_ext    = SUM_W'(quotient);
        d_val    = d_neg_reg ? -q_ext : q_ext;

        if (sum_reg > DRIVE_MAX_Q)
        begin
            clamped = DRIVE_MAX_Q;
        end
        else if (sum_reg < DRIVE_MIN_Q)
        begin
            clamped = DRIVE_MIN_Q;
        end
        else
        begin
            clamped = sum_reg;
        end
        clamped_abs = clamped[SUM_W-1] ? -clamped : clamped;
        clamp_mag   = clamped_abs[CLAMP_W-1:0];
        drive_mag   = OUT_W'(clamp_mag[CLAMP_W-1:Q_FRAC]);
        half_mag    = OUT_W'(clamp_mag[CLAMP_W-1:Q_FRAC+1]);
        // truncate toward zero on the magnitude, then restore the sign
        drive_new   = clamped[SUM_W-1] ? -drive_mag : drive_mag;
        pulse_new   = clamped[SUM_W-1] ? PULSE_CENTER + half_mag : PULSE_CENTER - half_mag;
    end

    prc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (div_eff),
        .quotient (quotient),
        .last     (div_last)
    );

    // state carried from sample to sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
        end
        else if (fire && uc.op == OP_MUL_D)
        begin
            acc_reg  <= in_band ? acc_sat : '0;
            prev_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            unique case (uc.op)
                OP_LOAD_ERR: err_reg <= err_new;
                OP_MUL_P:    prod_reg <= product;
                OP_MUL_I:
                begin
                    sum_reg  <= SUM_W'(prod_reg);
                    prod_reg <= product;
                end
                OP_MUL_D:    prod_reg <= product;
                OP_DIV_LOAD:
                begin
                    sum_reg   <= sum_reg + SUM_W'(acc_reg);
                    d_neg_reg <= prod_reg[PROD_W-1];
                end
                OP_DIV_STEP: ;
                OP_ADD_D:    sum_reg <= sum_reg + d_val;
                OP_EMIT:
                begin
                    drive_reg <= drive_new;
                    pulse_reg <= pulse_new;
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && uc.op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.drive       = drive_reg;
    assign result.rotor_pulse = pulse_reg;

    // ---------------- assertions ----------------
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> (step_reg == ST_MUL_P))
        else $error("sample beat did not start the multiply steps");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg == ST_EMIT))
        else $error("result valid raised outside the emit step");

    a_band_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_MUL_D && !in_band) |=> (acc_reg == '0))
        else $error("integral not cleared outside the error band");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_DIV_RUN && div_last) |=> (step_reg == ST_ADD_D))
        else $error("sequencer did not leave the divide loop on its last step");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.drive >= DRIVE_LO && result.drive <= DRIVE_HI &&
                          result.rotor_pulse >= PULSE_MIN &&
                          result.rotor_pulse <= PULSE_MAX))
        else $error("result outside the clamped drive or pulse range");

endmodule

// ===== sim/pid_drive_checker.sv =====
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the register port and both channels of the PID rotor pulse
// controller. It keeps its own copy of the gains, the setpoint, the integral
// and the last error, works out the drive and rotor pulse for every sample
// beat, and compares each result beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module pid_drive_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [prc_pkg::ADDR_W-1:0] paddr,
    input  logic [prc_pkg::DATA_W-1:0] pwdata,
    prc_in_if                          sample_mon,
    prc_out_if                         result_mon,
    input  logic                       wrap_up,
    output int                         fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam int     PRINT_CAP = 40;
    localparam longint Q_ONE     = longint'(1) <<< Q_FRAC;

    typedef struct packed {
        logic signed [OUT_W-1:0] drive;
        logic [OUT_W-1:0]        rotor_pulse;
    } pid_result_t;

    logic signed [IN_W-1:0] cfg_target;
    logic [GAIN_W-1:0]      cfg_kp;
    logic [GAIN_W-1:0]      cfg_ki;
    logic [GAIN_W-1:0]      cfg_kd;
    logic [DIV_W-1:0]       cfg_div;

    longint      integ_q16;
    longint      last_err;
    pid_result_t pending_drive[$];
    pid_result_t want;
    logic        wrapped;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // One control step: updates integral and last error, returns the outputs.
    function automatic pid_result_t compute_drive(input logic signed [IN_W-1:0] meas);
        longint      err;
        longint      p_q16;
        longint      d_q16;
        longint      nxt;
        longint      divisor;
        longint      sum_q16;
        pid_result_t r;
        err   = longint'(meas) - longint'(cfg_target);
        p_q16 = longint'(cfg_kp) * err;
        if (err > longint'(BAND_LO) && err < longint'(BAND_HI))
        begin
            nxt = integ_q16 + longint'(cfg_ki) * err;
            if (nxt > longint'(ACC_MAX))
                nxt = longint'(ACC_MAX);
            else if (nxt < longint'(ACC_MIN))
                nxt = longint'(ACC_MIN);
            integ_q16 = nxt;
        end
        else
        begin
            integ_q16 = 0;
        end
        // a zero time step divides by one
        divisor  = (cfg_div == '0) ? longint'(1) : longint'(cfg_div);
        d_q16    = (longint'(cfg_kd) * (err - last_err)) / divisor;
        last_err = err;
        sum_q16  = p_q16 + integ_q16 + d_q16;
        if (sum_q16 > longint'(DRIVE_MAX_Q))
            sum_q16 = longint'(DRIVE_MAX_Q);
        else if (sum_q16 < longint'(DRIVE_MIN_Q))
            sum_q16 = longint'(DRIVE_MIN_Q);
        r.drive       = OUT_W'(sum_q16 / Q_ONE);
        r.rotor_pulse = OUT_W'(longint'(PULSE_CENTER) - sum_q16 / (2 * Q_ONE));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_target = TARGET_RST;
            cfg_kp     = GAIN_P_RST;
            cfg_ki     = GAIN_I_RST;
            cfg_kd     = GAIN_D_RST;
            cfg_div    = STEP_DIV_RST;
            integ_q16  = 0;
            last_err   = 0;
            wrapped    = 1'b0;
            pending_drive.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                unique case (paddr[ADDR_W-1:2])
                    REG_TARGET:   cfg_target = pwdata[IN_W-1:0];
                    REG_GAIN_P:   cfg_kp     = pwdata[GAIN_W-1:0];
                    REG_GAIN_I:   cfg_ki     = pwdata[GAIN_W-1:0];
                    REG_GAIN_D:   cfg_kd     = pwdata[GAIN_W-1:0];
                    REG_STEP_DIV: cfg_div    = pwdata[DIV_W-1:0];
                    default: ;
                endcase
            end

            if (result_mon.valid && result_mon.ready)
            begin
                if (pending_drive.size() == 0)
                begin
                    report_mismatch($sformatf("result beat drive %0d pulse %0d with no sample pending",
                                              result_mon.drive, result_mon.rotor_pulse));
                end
                else
                begin
                    want = pending_drive.pop_front();
                    if (result_mon.drive !== want.drive)
                        report_mismatch($sformatf("drive %0d, predicted %0d",
                                                  result_mon.drive, want.drive));
                    if (result_mon.rotor_pulse !== want.rotor_pulse)
                        report_mismatch($sformatf("rotor_pulse %0d, predicted %0d",
                                                  result_mon.rotor_pulse, want.rotor_pulse));
                end
            end

            if (sample_mon.valid && sample_mon.ready)
                pending_drive.push_back(compute_drive(sample_mon.measured_time));

            if (wrap_up && !wrapped)
            begin
                wrapped = 1'b1;
                if (pending_drive.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived", pending_drive.size()));
            end
        end
    end

    initial fail_count = 0;

endmodule

// ===== sim/pid_rotor_pulse_controller_tb.sv =====
// ----------------------------------------------------------------------------
// pid_rotor_pulse_controller_tb
// Drives measured time samples and register writes into the PID rotor pulse
// controller: a directed opening at reset settings, then random phases under
// extreme, degenerate and random gains. Both channels stall in random bursts,
// and once the result side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module pid_rotor_pulse_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 250;
    localparam int HOLD_AT      = 450;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 60;

    typedef enum int {
        PAT_NOISE,
        PAT_BAND,
        PAT_RISE,
        PAT_FALL,
        PAT_EDGE
    } sample_pattern_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              wrap_up;
    int                fail_count;

    int              samples_sent;
    int              results_seen;
    int              cycle_count;
    int              stall_left;
    int              run_left;
    bit              quiet;
    bit              long_hold;
    sample_pattern_t pattern;
    logic signed [IN_W-1:0] cur_target;

    prc_in_if  sample_ch ();
    prc_out_if result_ch ();

    pid_rotor_pulse_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    pid_drive_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .sample_mon (sample_ch),
        .result_mon (result_ch),
        .wrap_up    (wrap_up),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial results_seen = 0;
    always @(posedge clk)
        if (result_ch.valid && result_ch.ready)
            results_seen++;

    // result side: random stall bursts, none in the quiet tail
    initial
    begin
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (long_hold)
                result_ch.ready <= 1'b0;
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // hold the result side off once, long enough to back up the sample side
    initial
    begin
        long_hold = 1'b0;
        wait (results_seen >= HOLD_AT);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    task automatic offer_sample(input logic signed [IN_W-1:0] meas);
        @(negedge clk);
        sample_ch.valid         <= 1'b1;
        sample_ch.measured_time <= meas;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic idle_input(input int n);
        @(negedge clk);
        sample_ch.valid         <= 1'b0;
        sample_ch.measured_time <= IN_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // wait for every result, then rewrite all five registers
    task automatic load_settings(input logic signed [IN_W-1:0] target,
                                 input logic [GAIN_W-1:0] kp,
                                 input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd,
                                 input logic [DIV_W-1:0] divisor);
        idle_input(1);
        while (results_seen < samples_sent) @(posedge clk);
        write_reg(REG_TARGET, DATA_W'(target));
        write_reg(REG_GAIN_P, DATA_W'(kp));
        write_reg(REG_GAIN_I, DATA_W'(ki));
        write_reg(REG_GAIN_D, DATA_W'(kd));
        write_reg(REG_STEP_DIV, DATA_W'(divisor));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_target = target;
    endtask

    // error patterns: noise, in-band wander, same-sign runs that push the
    // integral toward saturation, and values around the band edge
    function automatic logic signed [IN_W-1:0] pick_sample();
        int     pick;
        longint err;
        longint meas;
        if (run_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                pattern = PAT_NOISE;
            else if (pick < 4)
                pattern = PAT_BAND;
            else if (pick < 6)
                pattern = PAT_RISE;
            else if (pick < 8)
                pattern = PAT_FALL;
            else
                pattern = PAT_EDGE;
            run_left = $urandom_range(5, 120);
        end
        run_left--;
        unique case (pattern)
            PAT_NOISE: return IN_W'($urandom);
            PAT_BAND:  err = longint'($urandom_range(0, 798)) - 399;
            PAT_RISE:  err = longint'($urandom_range(1, 399));
            PAT_FALL:  err = -longint'($urandom_range(1, 399));
            default:   err = ($urandom_range(0, 1) ? 1 : -1) * longint'($urandom_range(395, 405));
        endcase
        meas = longint'(cur_target) + err;
        if (meas > 32767)
            meas = 32767;
        else if (meas < -32768)
            meas = -32768;
        return IN_W'(meas);
    endfunction

    task automatic random_phase(input int count);
        repeat (count)
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
                idle_input($urandom_range(1, 6));
            offer_sample(pick_sample());
        end
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        wrap_up <= 1'b0;
        sample_ch.valid         <= 1'b0;
        sample_ch.measured_time <= '0;
        samples_sent = 0;
        run_left     = 0;
        pattern      = PAT_BAND;
        quiet        = 1'b0;
        cur_target   = TARGET_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, band edges, a short in-band run
        offer_sample(16'sh8000);
        offer_sample(16'sh7FFF);
        offer_sample(16'sh8000);
        offer_sample(16'sd1000);
        offer_sample(16'sd1399);
        offer_sample(16'sd1400);
        offer_sample(16'sd1401);
        offer_sample(16'sd601);
        offer_sample(16'sd600);
        offer_sample(16'sd599);
        offer_sample(16'sd1000);
        offer_sample(16'sd1399);
        offer_sample(16'sd1399);
        offer_sample(16'sd1399);
        offer_sample(16'sd0);
        offer_sample(16'sd32767);
        offer_sample(16'sd1000);
        random_phase(PHASE_ITEMS);

        // all gains and the divisor at their maximum, lowest setpoint
        load_settings(16'sh8000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF);
        random_phase(PHASE_ITEMS);

        // zero gains, zero divisor, highest setpoint
        load_settings(16'sh7FFF, '0, '0, '0, '0);
        random_phase(PHASE_ITEMS);

        // strong integral with a unit divisor: drives saturation
        load_settings(16'sd0, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 8'd1);
        random_phase(PHASE_ITEMS);

        load_settings(IN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                      GAIN_W'($urandom), DIV_W'($urandom));
        random_phase(PHASE_ITEMS);

        load_settings(IN_W'($urandom), GAIN_W'($urandom_range(0, 262143)),
                      GAIN_W'($urandom_range(0, 16383)), GAIN_W'($urandom_range(0, 262143)),
                      DIV_W'($urandom_range(0, 16)));
        random_phase(PHASE_ITEMS);

        load_settings(TARGET_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, STEP_DIV_RST);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);

        idle_input(1);
        while (results_seen < samples_sent) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        wrap_up <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/prc_pkg.sv
rtl/core/prc_in_if.sv
rtl/core/prc_out_if.sv
rtl/core/prc_div.sv
rtl/core/pid_rotor_pulse_controller.sv
sim/pid_drive_checker.sv
sim/pid_rotor_pulse_controller_tb.sv
